### rtl/cqs_pkg.sv
// shared types and constants for the circular queue with search
package cqs_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - SLOT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_SRCH = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // source of the result loaded into the output or park register
    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_EMPTY,
        RES_DEQ,
        RES_HIT,
        RES_MISS,
        RES_PARK
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     enq_write;
        logic     deq_pop;
        logic     rd_en;
        logic     rd_head;
        logic     res_load;
        logic     res_park;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/cqs_datapath.sv
// queue storage, head/tail pointers, search compare and output register
module cqs_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cqs_pkg::dp_cmd_t             cmd,
    output cqs_pkg::dp_stat_t            stat,
    input  logic signed [cqs_pkg::DATA_W-1:0] data_in,
    input  logic signed [cqs_pkg::DATA_W-1:0] search_key,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cqs_pkg::STAT_W-1:0]   status,
    output logic signed [cqs_pkg::DATA_W-1:0] value_out,
    output logic [cqs_pkg::SLOT_W-1:0]   found_slot
);
    import cqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] k);
        next_slot = (k == LAST_SLOT) ? '0 : k + 1'b1;
    endfunction

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          rd_vld_reg;
    logic          rd_last_reg;
    logic [AW-1:0] rd_slot_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] key_reg;

    logic          out_vld_reg, out_vld_next;
    status_t       out_status_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    status_t       park_status_reg;
    logic signed [DATA_W-1:0] park_value_reg;
    logic [SLOT_W-1:0] park_slot_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    status_t       res_status;
    logic signed [DATA_W-1:0] res_value;
    logic [SLOT_W-1:0] res_slot;

    assign wr_addr = empty_reg ? '0 : next_slot(tail_reg);
    assign rd_addr = cmd.rd_head ? head_reg : ptr_reg;

    assign stat.full     = !empty_reg && (next_slot(tail_reg) == head_reg);
    assign stat.empty    = empty_reg;
    assign stat.hit      = rd_vld_reg && (rd_data_reg == key_reg);
    assign stat.last     = rd_vld_reg && rd_last_reg;
    assign stat.out_free = !out_vld_reg || out_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ptr_next   = ptr_reg;
        if (cmd.enq_write)
        begin
            tail_next  = wr_addr;
            empty_next = 1'b0;
            if (empty_reg)
            begin
                head_next = '0;
            end
        end
        if (cmd.deq_pop)
        begin
            // popping the only entry resets both pointers to slot 0
            if (head_reg == tail_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
            end
            else
            begin
                head_next = next_slot(head_reg);
            end
        end
        if (cmd.rd_en)
        begin
            ptr_next = next_slot(rd_addr);
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_value  = '0;
        res_slot   = '0;
        case (cmd.res_sel)
            RES_OK:
            begin
                res_status = ST_OK;
            end
            RES_FULL:
            begin
                res_status = ST_FULL;
            end
            RES_EMPTY:
            begin
                res_status = ST_EMPTY;
            end
            RES_DEQ:
            begin
                res_value = rd_data_reg;
            end
            RES_HIT:
            begin
                res_slot = SLOT_W'(rd_slot_reg);
            end
            RES_MISS:
            begin
                res_status = ST_MISSING;
            end
            RES_PARK:
            begin
                res_status = park_status_reg;
                res_value  = park_value_reg;
                res_slot   = park_slot_reg;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.res_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            empty_reg   <= empty_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= cmd.rd_en;
            out_vld_reg <= out_vld_next;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            mem[wr_addr] <= data_in;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_slot_reg <= rd_addr;
            rd_last_reg <= (rd_addr == tail_reg);
        end
        if (cmd.accept)
        begin
            key_reg <= search_key;
        end
        if (cmd.res_load)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_slot_reg   <= res_slot;
        end
        if (cmd.res_park)
        begin
            park_status_reg <= res_status;
            park_value_reg  <= res_value;
            park_slot_reg   <= res_slot;
        end
    end

    assign out_valid  = out_vld_reg;
    assign status     = out_status_reg;
    assign value_out  = out_value_reg;
    assign found_slot = out_slot_reg;

endmodule

### rtl/cqs_ctrl.sv
// control state machine sequencing enqueue, dequeue and search
module cqs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cqs_pkg::MODE_W-1:0] mode,
    input  cqs_pkg::dp_stat_t          stat,
    output cqs_pkg::dp_cmd_t           cmd
);
    import cqs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEQ  = 4'b0010,
        S_SRCH = 4'b0100,
        S_PARK = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = accept;
        cmd.enq_write = 1'b0;
        cmd.deq_pop   = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_head   = 1'b0;
        cmd.res_load  = 1'b0;
        cmd.res_park  = 1'b0;
        cmd.res_sel   = RES_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode_t'(mode))
                        MODE_ENQ:
                        begin
                            cmd.res_load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_sel = RES_FULL;
                            end
                            else
                            begin
                                cmd.enq_write = 1'b1;
                            end
                        end
                        MODE_DEQ, MODE_SRCH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_sel  = RES_EMPTY;
                                cmd.res_load = 1'b1;
                            end
                            else
                            begin
                                // first read always starts at the head slot
                                cmd.rd_en   = 1'b1;
                                cmd.rd_head = 1'b1;
                                state_next  = (mode_t'(mode) == MODE_DEQ) ? S_DEQ : S_SRCH;
                            end
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                cmd.deq_pop = 1'b1;
                cmd.res_sel = RES_DEQ;
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.res_park = 1'b1;
                    state_next   = S_PARK;
                end
            end
            S_SRCH:
            begin
                if (stat.hit || stat.last)
                begin
                    cmd.res_sel = stat.hit ? RES_HIT : RES_MISS;
                    if (stat.out_free)
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.res_park = 1'b1;
                        state_next   = S_PARK;
                    end
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_PARK:
            begin
                cmd.res_sel = RES_PARK;
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/circular_queue_with_search.sv
// Circular FIFO queue of DEPTH signed 32-bit words with enqueue, dequeue and
// key search. One beat in gives one beat out. Enqueue, and any operation that
// ends in full or empty status, loads its result on accept; dequeue reads the
// head slot through the one registered read port of the storage first; search
// reads one slot per cycle from head toward tail through that port until a hit
// or the tail slot, examining at most DEPTH entries. A result waits in the
// output register, and the next beat is taken as soon as the controller is
// idle and that register is free or being emptied in the same cycle. Storage
// is not cleared at reset; only written slots are ever read.
module circular_queue_with_search #(
    parameter int DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cqs_pkg::S_TDATA_W-1:0] s_tdata,  // data_in, search_key
    input  logic [cqs_pkg::MODE_W-1:0]    s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cqs_pkg::M_TDATA_W-1:0] m_tdata,  // value_out, found_slot, zero pad
    output logic [cqs_pkg::STAT_W-1:0]    m_tuser   // status
);
    import cqs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic signed [DATA_W-1:0] value_out;
    logic [SLOT_W-1:0]        found_slot;

    cqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    cqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .data_in    (s_tdata[DATA_W-1:0]),
        .search_key (s_tdata[2*DATA_W-1:DATA_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .status     (m_tuser),
        .value_out  (value_out),
        .found_slot (found_slot)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, found_slot, value_out};

endmodule

### rtl/cqs_checker.sv
// port-level checks for the circular queue with search, bound to the top
module cqs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cqs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cqs_pkg::STAT_W-1:0]    m_tuser
);
    import cqs_pkg::*;

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // input is only taken when the output register can take the result
    a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while output register blocked");

    // failed operations return zero value and slot
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero payload on failed operation");

    // an accepted beat cannot be followed by another accept on the next edge
    // unless the first produced its result at once
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !s_tready || m_tvalid)
        else $error("new beat taken while previous result outstanding");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
